// ===== rtl/core/tcl_pkg.sv =====
package tcl_pkg;

  // Input item kinds
  localparam logic [1:0] KIND_CHAR  = 2'd0;
  localparam logic [1:0] KIND_END   = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  // Result kinds
  localparam logic RES_GLYPH = 1'b0;
  localparam logic RES_TOP   = 1'b1;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LINES    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WRAP_COLUMNS = 2'd1;

  // Character codes
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TILDE = 8'h7E;
  localparam logic [7:0] CH_QMARK = 8'h3F;

  typedef struct packed {
    logic        result_kind;
    logic [15:0] line_number;
    logic [7:0]  column;
    logic [3:0]  atlas_col;
    logic [3:0]  atlas_row;
    logic [31:0] glyph_rgba;
  } result_t;

  typedef struct packed {
    logic [31:0] rgba;
    logic [7:0]  code;
    logic [1:0]  kind;
  } item_t;

endpackage

// ===== rtl/core/tcl_if.sv =====
interface tcl_in_if;
  import tcl_pkg::*;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  code;
  logic [31:0] rgba;
  modport source (output valid, kind, code, rgba, input ready);
  modport sink   (input valid, kind, code, rgba, output ready);
endinterface

interface tcl_out_if;
  import tcl_pkg::*;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [15:0] line_number;
  logic [7:0]  column;
  logic [3:0]  atlas_col;
  logic [3:0]  atlas_row;
  logic [31:0] glyph_rgba;
  modport source (output valid, result_kind, line_number, column, atlas_col, atlas_row,
                  glyph_rgba, input ready);
  modport sink   (input valid, result_kind, line_number, column, atlas_col, atlas_row,
                  glyph_rgba, output ready);
endinterface

interface tcl_cfg_if;
  import tcl_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [7:0]           data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/tcl_core.sv =====
module tcl_core
  import tcl_pkg::*;
#(
  parameter int unsigned COLUMN_LIMIT = 256,
  parameter int unsigned COL_W        = $clog2(COLUMN_LIMIT + 1)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 item_acc,
  input  item_t                item,
  input  logic                 cfg_wr,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data,
  output logic                 res_valid,
  output result_t              res,
  output logic [COL_W-1:0]     cursor_column
);

  localparam logic [COL_W-1:0] LIMIT = COL_W'(COLUMN_LIMIT);

  logic [7:0]       max_lines_r, wrap_columns_r;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [15:0]      line_r, line_nxt, top_r, top_nxt;

  // Effective wrap width
  logic [COL_W-1:0] wrap_w;
  always_comb begin
    if (wrap_columns_r != 8'd0 && {1'b0, wrap_columns_r} <= 9'(COLUMN_LIMIT)) begin
      wrap_w = COL_W'(wrap_columns_r);
    end else begin
      wrap_w = LIMIT;
    end
  end

  // Tab target and wrap before a character
  logic [COL_W:0]   tab_next;
  logic             at_wrap;
  logic [COL_W-1:0] ch_col;
  logic [15:0]      ch_line;
  logic [7:0]       glyph_idx;
  assign tab_next = {1'b0, col_r | COL_W'(3)} + (COL_W+1)'(1);
  assign at_wrap  = col_r >= wrap_w;
  assign ch_col   = at_wrap ? '0 : col_r;
  assign ch_line  = at_wrap ? line_r + 16'd1 : line_r;

  always_comb begin
    if (item.code > CH_SPACE && item.code <= CH_TILDE) begin
      glyph_idx = item.code - CH_SPACE;
    end else begin
      glyph_idx = CH_QMARK - CH_SPACE;
    end
  end

  // End of text: visible lines and retire count
  logic [16:0] visible, excess;
  assign visible = {1'b0, line_r - top_r} + 17'(col_r != '0);
  assign excess  = visible - 17'(max_lines_r);

  // Next state and result
  always_comb begin
    col_nxt   = col_r;
    line_nxt  = line_r;
    top_nxt   = top_r;
    res_valid = 1'b0;
    res       = '0;
    case (item.kind)
      KIND_CHAR: begin
        if (item.code == CH_LF) begin
          line_nxt = line_r + 16'd1;
          col_nxt  = '0;
        end else if (item.code == CH_CR) begin
          col_nxt = col_r;
        end else if (item.code == CH_TAB) begin
          if (col_r[1:0] != 2'd0) begin
            if (tab_next <= {1'b0, wrap_w}) begin
              col_nxt = tab_next[COL_W-1:0];
            end else begin
              line_nxt = line_r + 16'd1;
              col_nxt  = '0;
            end
          end
        end else begin
          line_nxt = ch_line;
          col_nxt  = ch_col + COL_W'(1);
          if (item.code != CH_SPACE) begin
            res_valid       = 1'b1;
            res.result_kind = RES_GLYPH;
            res.line_number = ch_line;
            res.column      = 8'(ch_col);
            res.atlas_col   = glyph_idx[3:0];
            res.atlas_row   = glyph_idx[7:4];
            res.glyph_rgba  = item.rgba;
          end
        end
      end
      KIND_END: begin
        if (max_lines_r != 8'd0 && visible > 17'(max_lines_r)) begin
          top_nxt = top_r + excess[15:0];
        end
        res_valid       = 1'b1;
        res.result_kind = RES_TOP;
        res.line_number = top_nxt;
      end
      KIND_CLEAR: begin
        col_nxt  = '0;
        line_nxt = '0;
        top_nxt  = '0;
      end
      default: begin
        col_nxt = col_r;
      end
    endcase
  end

  // Cursor state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      line_r <= '0;
      top_r  <= '0;
    end else if (item_acc) begin
      col_r  <= col_nxt;
      line_r <= line_nxt;
      top_r  <= top_nxt;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_lines_r    <= '0;
      wrap_columns_r <= '0;
    end else if (cfg_wr) begin
      if (cfg_index == REG_MAX_LINES) begin
        max_lines_r <= cfg_data;
      end else if (cfg_index == REG_WRAP_COLUMNS) begin
        wrap_columns_r <= cfg_data;
      end
    end
  end

  assign cursor_column = col_r;

endmodule

// ===== rtl/core/text_console_layout_top.sv =====
// Channel | Dir | Payload                                           | Handshake
// in_ch   | in  | kind, code, rgba                                  | valid/ready
// out_ch  | out | result_kind, line_number, column, atlas_col,      | valid/ready
//         |     | atlas_row, glyph_rgba                             |
// cfg_ch  | in  | index, data (0 max_lines, 1 wrap_columns)         | valid/ready
//
// One item per cycle while in_ch is ready; a result shows on out_ch the cycle
// after acceptance if none older waits. Cursor logic is compare/increment.
// A two-entry result queue keeps in_ch ready while one result waits; in_ch
// stalls only when both entries are full. cfg_ch is always ready.
// rst_n is synchronous, active low; it clears cursor, registers and the queue.
module text_console_layout_top
  import tcl_pkg::*;
#(
  parameter int unsigned COLUMN_LIMIT = 256
) (
  input  logic     clk,
  input  logic     rst_n,
  tcl_in_if.sink   in_ch,
  tcl_out_if.source out_ch,
  tcl_cfg_if.sink  cfg_ch
);

  localparam int unsigned COL_W = $clog2(COLUMN_LIMIT + 1);

  item_t            item;
  logic             item_acc, res_valid, pop;
  result_t          res;
  logic [COL_W-1:0] cursor_column;
  result_t          head_r, tail_r;
  logic [1:0]       cnt_r;

  assign item     = '{rgba: in_ch.rgba, code: in_ch.code, kind: in_ch.kind};
  assign in_ch.ready = (cnt_r != 2'd2);
  assign item_acc = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  tcl_core #(
    .COLUMN_LIMIT(COLUMN_LIMIT),
    .COL_W       (COL_W)
  ) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_acc     (item_acc),
    .item         (item),
    .cfg_wr       (cfg_ch.valid && cfg_ch.ready),
    .cfg_index    (cfg_ch.index),
    .cfg_data     (cfg_ch.data),
    .res_valid    (res_valid),
    .res          (res),
    .cursor_column(cursor_column)
  );

  // Result queue, two entries
  logic push;
  assign push = item_acc && res_valid;
  assign pop  = out_ch.valid && out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (cnt_r == 2'd0 || (cnt_r == 2'd1 && pop)) begin
      head_r <= res;
    end else if (cnt_r == 2'd2 && pop) begin
      head_r <= tail_r;
    end
    if (push && cnt_r == 2'd1 && !pop) begin
      tail_r <= res;
    end
  end

  assign out_ch.valid       = (cnt_r != 2'd0);
  assign out_ch.result_kind = head_r.result_kind;
  assign out_ch.line_number = head_r.line_number;
  assign out_ch.column      = head_r.column;
  assign out_ch.atlas_col   = head_r.atlas_col;
  assign out_ch.atlas_row   = head_r.atlas_row;
  assign out_ch.glyph_rgba  = head_r.glyph_rgba;

  // Checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("result queue overflow");

  a_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cursor_column <= COL_W'(COLUMN_LIMIT))
    else $error("cursor column beyond limit");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    item_acc && in_ch.kind == KIND_CLEAR |=> cursor_column == '0)
    else $error("clear did not reset cursor");

  a_end_result: assert property (@(posedge clk) disable iff (!rst_n)
    item_acc && in_ch.kind == KIND_END && !pop |=> cnt_r == $past(cnt_r) + 2'd1)
    else $error("end of text gave no result");

endmodule

// ===== verif/tcl_layout_checker.sv =====
`timescale 1ns / 1ps

// Watches the three channels, keeps a cycle-free copy of the console layout
// and compares every result item against the oldest prediction.
module tcl_layout_checker
  import tcl_pkg::*;
#(
  parameter int unsigned COLUMN_LIMIT = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  tcl_in_if           in_ch,
  tcl_out_if          out_ch,
  tcl_cfg_if          cfg_ch,
  output int unsigned fail_count,
  output int unsigned pending
);

  // Shadow configuration and cursor state
  logic [7:0]  max_lines_r    = '0;
  logic [7:0]  wrap_columns_r = '0;
  logic [8:0]  cur_col        = '0;
  logic [15:0] cur_line       = '0;
  logic [15:0] top_line       = '0;

  // Predicted results, oldest first
  result_t layout_q[$];
  result_t oldest;

  function automatic logic [8:0] wrap_width();
    if (wrap_columns_r != 8'd0 && wrap_columns_r <= COLUMN_LIMIT)
      return {1'b0, wrap_columns_r};
    return 9'(COLUMN_LIMIT);
  endfunction

  function automatic void open_line();
    cur_line = cur_line + 16'd1;
    cur_col  = '0;
  endfunction

  // Advance the layout by one input item; queue the result it causes, if any
  function automatic void lay_out_item(input logic [1:0] kind, input logic [7:0] code,
                                       input logic [31:0] rgba);
    logic [8:0]  w;
    logic [9:0]  tab_stop;
    logic [7:0]  idx;
    logic [16:0] span;
    logic [16:0] shown;
    result_t     r;
    w = wrap_width();
    r = '0;
    case (kind)
      KIND_CHAR: begin
        if (code == CH_LF) begin
          open_line();
        end else if (code == CH_TAB) begin
          // off a stop, pad to next multiple of four, or break the line at the wrap
          if (cur_col[1:0] != 2'b00) begin
            tab_stop = {1'b0, cur_col | 9'd3} + 10'd1;
            if (tab_stop <= {1'b0, w})
              cur_col = tab_stop[8:0];
            else
              open_line();
          end
        end else if (code != CH_CR) begin
          // wrap first, also when the width shrank under the cursor
          if (cur_col >= w)
            open_line();
          if (code == CH_SPACE) begin
            cur_col = cur_col + 9'd1;
          end else begin
            idx = (code > CH_SPACE && code <= CH_TILDE) ? code - CH_SPACE
                                                         : CH_QMARK - CH_SPACE;
            r.result_kind = RES_GLYPH;
            r.line_number = cur_line;
            r.column      = cur_col[7:0];
            r.atlas_col   = idx[3:0];
            r.atlas_row   = idx[7:4];
            r.glyph_rgba  = rgba;
            layout_q.push_back(r);
            cur_col = cur_col + 9'd1;
          end
        end
      end
      KIND_END: begin
        // line distance taken mod 2^16; an empty current line is not shown
        span  = {1'b0, 16'(cur_line - top_line)} + 17'd1;
        shown = (cur_col == 9'd0) ? span - 17'd1 : span;
        if (max_lines_r != 8'd0 && shown > {9'd0, max_lines_r})
          top_line = top_line + 16'(shown - {9'd0, max_lines_r});
        r.result_kind = RES_TOP;
        r.line_number = top_line;
        layout_q.push_back(r);
      end
      KIND_CLEAR: begin
        cur_col  = '0;
        cur_line = '0;
        top_line = '0;
      end
      default: ;
    endcase
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      fail_count++;
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
    end
  endfunction

  // Sample all handshakes at the clock edge
  always @(posedge clk) begin
    if (!rst_n) begin
      fail_count = 0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          REG_MAX_LINES:    max_lines_r    = cfg_ch.data;
          REG_WRAP_COLUMNS: wrap_columns_r = cfg_ch.data;
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        if (layout_q.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result: expected none, actual kind %0d line %0h col %0h",
                   $time, out_ch.result_kind, out_ch.line_number, out_ch.column);
        end else begin
          oldest = layout_q[0];
          layout_q.delete(0);
          check_field("result_kind", 32'(oldest.result_kind), 32'(out_ch.result_kind));
          check_field("line_number", 32'(oldest.line_number), 32'(out_ch.line_number));
          check_field("column", 32'(oldest.column), 32'(out_ch.column));
          check_field("atlas_col", 32'(oldest.atlas_col), 32'(out_ch.atlas_col));
          check_field("atlas_row", 32'(oldest.atlas_row), 32'(out_ch.atlas_row));
          check_field("glyph_rgba", oldest.glyph_rgba, out_ch.glyph_rgba);
        end
      end
      if (in_ch.valid && in_ch.ready)
        lay_out_item(in_ch.kind, in_ch.code, in_ch.rgba);
    end
    pending = layout_q.size();
  end

endmodule

// ===== verif/tb_text_console_layout_top.sv =====
`timescale 1ns / 1ps

module tb_text_console_layout_top;
  import tcl_pkg::*;

  localparam logic [1:0]  KIND_UNUSED = 2'd3;
  localparam int unsigned IDLE_LIMIT  = 1000;

  logic        clk   = 1'b0;
  logic        rst_n = 1'b0;
  bit          calm  = 1'b0;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned quiet_cycles = 0;
  int unsigned sink_hold    = 0;
  int unsigned sink_stall;

  tcl_in_if  in_ch();
  tcl_out_if out_ch();
  tcl_cfg_if cfg_ch();

  text_console_layout_top DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  tcl_layout_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_ch     (cfg_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #2 clk = ~clk;

  // Result side: random stall after each accepted result
  always @(posedge clk) begin
    if (!rst_n) begin
      sink_hold    <= 0;
      out_ch.ready <= 1'b0;
    end else if (sink_hold != 0) begin
      sink_hold    <= sink_hold - 1;
      out_ch.ready <= (sink_hold == 1);
    end else if (out_ch.valid && out_ch.ready) begin
      sink_stall    = calm ? 0 : $urandom_range(0, 6);
      out_ch.ready <= (sink_stall == 0);
      sink_hold    <= sink_stall;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Watchdog: too long without any item moving
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one item after a random gap; returns at the accepting edge
  task automatic send_item(input logic [1:0] kind, input logic [7:0] code,
                           input logic [31:0] rgba);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind  <= kind;
    in_ch.code  <= code;
    in_ch.rgba  <= rgba;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic send_char(input logic [7:0] code);
    send_item(KIND_CHAR, code, $urandom());
  endtask

  // Stop offering items and wait for every outstanding result
  task automatic settle();
    in_ch.valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write both registers back to back; block must be idle
  task automatic configure(input logic [7:0] max_lines, input logic [7:0] wrap_columns);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= REG_MAX_LINES;
    cfg_ch.data  <= max_lines;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.index <= REG_WRAP_COLUMNS;
    cfg_ch.data  <= wrap_columns;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // One random item; lf_pct sets how often lines are broken by hand, zero bars clears
  task automatic send_random(input int unsigned lf_pct);
    int unsigned pick;
    logic [1:0]  kind;
    logic [7:0]  code;
    kind = KIND_CHAR;
    code = 8'($urandom_range(CH_SPACE + 1, CH_TILDE));
    pick = $urandom_range(0, 99);
    if ($urandom_range(0, 99) < lf_pct) code = CH_LF;
    else if (pick < 8) code = CH_TAB;
    else if (pick < 11) code = CH_CR;
    else if (pick < 21) code = CH_SPACE;
    else if (pick < 29) code = 8'($urandom_range(0, 255));
    else if (pick < 36) kind = KIND_END;
    else if (pick < 38) kind = (lf_pct != 0) ? KIND_CLEAR : KIND_END;
    else if (pick < 40) kind = KIND_UNUSED;
    if (kind != KIND_CHAR) code = 8'($urandom_range(0, 255));
    send_item(kind, code, $urandom());
  endtask

  task automatic random_phase(input logic [7:0] max_lines, input logic [7:0] wrap_columns,
                              input int unsigned count, input int unsigned lf_pct);
    settle();
    configure(max_lines, wrap_columns);
    for (int i = 0; i < count; i++) begin
      // switch between idling and back-to-back stretches
      if (i % 40 == 0) calm = ($urandom_range(0, 3) == 0);
      send_random(lf_pct);
    end
  endtask

  initial begin
    in_ch.valid  = 1'b0;
    in_ch.kind   = KIND_CHAR;
    in_ch.code   = '0;
    in_ch.rgba   = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_MAX_LINES;
    cfg_ch.data  = '0;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset settings, field extremes and every byte class
    send_item(KIND_CHAR, "A", 32'hFFFF_FFFF);
    send_item(KIND_CHAR, 8'h00, 32'h0000_0000);
    send_char(CH_TILDE);
    send_char(8'h7F);
    send_char(8'hFF);
    send_char(CH_SPACE);
    send_char(8'h21);
    send_char(CH_TAB);                    // mid-stop: pads to next stop
    send_char(CH_TAB);                    // on a stop: no move
    send_char(CH_CR);
    send_char(CH_LF);
    send_item(KIND_UNUSED, 8'hFF, $urandom());
    send_item(KIND_END, 8'($urandom_range(0, 255)), $urandom());
    send_item(KIND_CLEAR, 8'($urandom_range(0, 255)), $urandom());
    send_item(KIND_END, 8'($urandom_range(0, 255)), $urandom());

    // Directed: narrow wrap, tab breaking the line, retire to one line
    settle();
    configure(8'd1, 8'd3);
    send_char("a");
    send_char("b");
    send_char("c");
    send_char(CH_TAB);
    send_char("d");
    send_char("e");
    send_char("f");
    send_char("g");
    send_item(KIND_END, 8'h00, $urandom());

    // Many empty lines back to back, then retire down to the limit
    settle();
    configure(8'd5, 8'd0);
    calm = 1'b1;
    for (int i = 0; i < 30; i++) send_char(CH_LF);
    send_item(KIND_END, 8'h00, $urandom());
    for (int i = 0; i < 20; i++) send_char(CH_LF);
    for (int i = 0; i < 10; i++) send_random(0);
    send_item(KIND_END, 8'h00, $urandom());
    calm = 1'b0;

    // Random phases across register settings, extremes included
    random_phase(8'd0, 8'd0, 200, 0);
    random_phase(8'd255, 8'd255, 150, 1);
    random_phase(8'd1, 8'd1, 120, 10);
    random_phase(8'd4, 8'd16, 120, 8);
    random_phase(8'd2, 8'd7, 120, 10);
    random_phase(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 120, 6);
    random_phase(8'd0, 8'd4, 100, 5);
    random_phase(8'd255, 8'd0, 100, 3);

    settle();
    repeat (8) @(posedge clk);
    if (fail_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
